// ----- sv/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types and constants for the HSV to RGB pixel pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // Q1.8 unit and clamp ceiling for saturation and value
    localparam logic [8:0]  Q8_ONE      = 9'd256;
    // 6 * 5760: makes any 16-bit signed hue positive without changing it mod 5760
    localparam logic [16:0] HUE_OFFSET  = 17'd34560;
    // ceil(2^16 / 15): (u >> 6) / 15 == u / 960 for the offset hue range
    localparam logic [12:0] RECIP15_Q16 = 13'd4370;
    // ceil(2^8 / 6): exact q / 6 for q below 128
    localparam logic [5:0]  RECIP6_Q8   = 6'd43;
    // ceil(2^24 / 15): exact floor(r * 1024 / 15) for r below 960
    localparam logic [20:0] RECIP15_Q24 = 21'd1118482;
    // 1.0 in Q.24
    localparam logic [24:0] ONE_Q24     = 25'h100_0000;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // sector stage -> level stage
    typedef struct packed {
        logic       valid;
        t_sector    sector;
        logic [8:0] sat;
        logic [8:0] val;
        logic [15:0] frac;
    } t_frac;

    // level stage -> output stage, channel levels in Q.32 (at most 1.0)
    typedef struct packed {
        logic        valid;
        logic [32:0] red;
        logic [32:0] green;
        logic [32:0] blue;
    } t_level;

endpackage

// ----- sv/hsv_sector.sv -----
// ----------------------------------------------------------------------------
// hsv_sector
// Hue wrap, sector split and Q0.16 sector fraction; three register stages.
// ----------------------------------------------------------------------------
module hsv_sector import hsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_hue,
    input  logic [8:0]  i_saturation,
    input  logic [8:0]  i_brightness,
    output t_frac       o_frac
);

    // stage 1: offset hue, coarse quotient by 960, clamp S and V
    logic        r_v1, n_v1;
    logic [16:0] r_u, n_u;
    logic [6:0]  r_q, n_q;
    logic [8:0]  r_s1, n_s1;
    logic [8:0]  r_b1, n_b1;
    logic [23:0] w_qprod;

    always_comb begin
        n_v1    = i_valid;
        n_u     = {i_hue[15], i_hue} + HUE_OFFSET;
        w_qprod = 24'(n_u[16:6]) * 24'(RECIP15_Q16);
        n_q     = w_qprod[22:16];
        n_s1    = (i_saturation > Q8_ONE) ? Q8_ONE : i_saturation;
        n_b1    = (i_brightness > Q8_ONE) ? Q8_ONE : i_brightness;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
        r_u  <= n_u;
        r_q  <= n_q;
        r_s1 <= n_s1;
        r_b1 <= n_b1;
    end

    // stage 2: remainder within sector, sector = q mod 6
    logic        r_v2, n_v2;
    logic [9:0]  r_rem, n_rem;
    t_sector     r_sec, n_sec;
    logic [8:0]  r_s2;
    logic [8:0]  r_b2;
    logic [16:0] w_q960;
    logic [16:0] w_rem;
    logic [12:0] w_q6prod;
    logic [3:0]  w_q6;
    logic [6:0]  w_q6x6;
    logic [6:0]  w_mod6;

    always_comb begin
        n_v2     = r_v1;
        w_q960   = (17'(r_q) << 10) - (17'(r_q) << 6);
        w_rem    = r_u - w_q960;
        n_rem    = w_rem[9:0];
        w_q6prod = 13'(r_q) * 13'(RECIP6_Q8);
        w_q6     = w_q6prod[11:8];
        w_q6x6   = (7'(w_q6) << 2) + (7'(w_q6) << 1);
        w_mod6   = r_q - w_q6x6;
        n_sec    = t_sector'(w_mod6[2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= n_v2;
        end
        r_rem <= n_rem;
        r_sec <= n_sec;
        r_s2  <= r_s1;
        r_b2  <= r_b1;
    end

    // stage 3: f = floor(rem * 65536 / 960) = floor(rem * 1024 / 15)
    t_frac       r_out, n_out;
    logic [30:0] w_fprod;

    always_comb begin
        w_fprod      = 31'(r_rem) * 31'(RECIP15_Q24);
        n_out.valid  = r_v2;
        n_out.sector = r_sec;
        n_out.sat    = r_s2;
        n_out.val    = r_b2;
        n_out.frac   = w_fprod[29:14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= n_out.valid;
        end
        r_out.sector <= n_out.sector;
        r_out.sat    <= n_out.sat;
        r_out.val    <= n_out.val;
        r_out.frac   <= n_out.frac;
    end

    assign o_frac = r_out;

endmodule

// ----- sv/hsv_level.sv -----
// ----------------------------------------------------------------------------
// hsv_level
// Forms 1-S, 1-Sf, 1-S(1-f), picks 1.0 or one of them per channel by sector, scales by V.
// ----------------------------------------------------------------------------
module hsv_level import hsv_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_frac  i_frac,
    output t_level o_level
);

    // stage 4: per-channel factor in Q.24
    logic        r_v4, n_v4;
    logic [8:0]  r_val4;
    logic [24:0] r_ar, n_ar;
    logic [24:0] r_ag, n_ag;
    logic [24:0] r_ab, n_ab;
    logic [23:0] w_sf;
    logic [16:0] w_fc;
    logic [24:0] w_sfc;
    logic [24:0] w_aq;
    logic [24:0] w_at;
    logic [24:0] w_ap;

    always_comb begin
        n_v4  = i_frac.valid;
        w_sf  = 24'(i_frac.sat) * 24'(i_frac.frac);
        w_fc  = 17'h1_0000 - 17'(i_frac.frac);
        w_sfc = 25'(i_frac.sat) * 25'(w_fc);
        w_aq  = ONE_Q24 - 25'(w_sf);
        w_at  = ONE_Q24 - w_sfc;
        w_ap  = ONE_Q24 - (25'(i_frac.sat) << 16);
        case (i_frac.sector)
            SEC_RED_YEL: begin
                n_ar = ONE_Q24; n_ag = w_at;    n_ab = w_ap;
            end
            SEC_YEL_GRN: begin
                n_ar = w_aq;    n_ag = ONE_Q24; n_ab = w_ap;
            end
            SEC_GRN_CYN: begin
                n_ar = w_ap;    n_ag = ONE_Q24; n_ab = w_at;
            end
            SEC_CYN_BLU: begin
                n_ar = w_ap;    n_ag = w_aq;    n_ab = ONE_Q24;
            end
            SEC_BLU_MAG: begin
                n_ar = w_at;    n_ag = w_ap;    n_ab = ONE_Q24;
            end
            default: begin
                n_ar = ONE_Q24; n_ag = w_ap;    n_ab = w_aq;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= n_v4;
        end
        r_val4 <= i_frac.val;
        r_ar   <= n_ar;
        r_ag   <= n_ag;
        r_ab   <= n_ab;
    end

    // stage 5: level = V * factor, Q.32
    t_level      r_out, n_out;
    logic [33:0] w_lr;
    logic [33:0] w_lg;
    logic [33:0] w_lb;

    always_comb begin
        w_lr        = 34'(r_val4) * 34'(r_ar);
        w_lg        = 34'(r_val4) * 34'(r_ag);
        w_lb        = 34'(r_val4) * 34'(r_ab);
        n_out.valid = r_v4;
        n_out.red   = w_lr[32:0];
        n_out.green = w_lg[32:0];
        n_out.blue  = w_lb[32:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= n_out.valid;
        end
        r_out.red   <= n_out.red;
        r_out.green <= n_out.green;
        r_out.blue  <= n_out.blue;
    end

    assign o_level = r_out;

endmodule

// ----- sv/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pixel HSV to 8-bit RGB converter, fully pipelined.
// ----------------------------------------------------------------------------
// One pixel beat per clock: a beat is taken on every edge with start high
// (busy is always low, nothing inside ever stalls). Each result appears
// for one cycle with o_strobe high, in input order; there is no
// backpressure, so the receiver must take it then. Hue is signed 1/16
// degree and wraps mod 360 degrees; saturation and value are Q1.8 and
// clamp to 1.0. Zero value gives black and zero saturation gives grey;
// both fall out of the general path. Each beat passes through the six
// register stages: offset and coarse divide by 960, sector and
// remainder, sector fraction, one-minus factors, scale by V, then the
// x255 output stage.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_hue,
    input  logic [8:0]  i_saturation,
    input  logic [8:0]  i_brightness,
    output logic        o_strobe,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue
);

    t_frac  w_frac;
    t_level w_level;

    // pure pipeline: never refuses a beat
    assign busy = 1'b0;

    // stages 1-3
    hsv_sector u_sector (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (start),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_frac       (w_frac)
    );

    // stages 4-5
    hsv_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frac  (w_frac),
        .o_level (w_level)
    );

    // stage 6: channel = floor(level * 255 / 2^32), level*255 as (level<<8)-level
    logic        r_strobe;
    logic [7:0]  r_red, n_red;
    logic [7:0]  r_green, n_green;
    logic [7:0]  r_blue, n_blue;
    logic [40:0] w_sr;
    logic [40:0] w_sg;
    logic [40:0] w_sb;

    always_comb begin
        w_sr    = (41'(w_level.red) << 8) - 41'(w_level.red);
        w_sg    = (41'(w_level.green) << 8) - 41'(w_level.green);
        w_sb    = (41'(w_level.blue) << 8) - 41'(w_level.blue);
        n_red   = w_sr[39:32];
        n_green = w_sg[39:32];
        n_blue  = w_sb[39:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_level.valid;
        end
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_strobe = r_strobe;
    assign o_red    = r_red;
    assign o_green  = r_green;
    assign o_blue   = r_blue;

    // every accepted beat is followed by a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("result strobe missing six clocks after input beat");

    // no result strobe without a matching input beat
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##6 !o_strobe)
        else $error("result strobe without matching input beat");

    // zero saturation gives equal channels
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation == 9'd0)
            |-> ##6 (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give grey");

    // zero value gives black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_brightness == 9'd0)
            |-> ##6 (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
        else $error("zero value did not give black");

endmodule

// ----- sim/hsv_to_rgb_converter_test.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_test
// Self-checking bench for the HSV to RGB pixel converter. A short directed
// table covers black, grey, the six primary and secondary hues, hue wrap and
// the saturation/value clamp; typed rows hold hand-computed answers. Then a
// long random run follows, with random start gaps and one full drain. Other
// results are checked against a bit-exact model of the fixed-point math.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_test import hsv_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HUE_FULL     = 5760;   // 360 degrees in 1/16 degree
    localparam int HUE_SECTOR   = 960;    // 60 degrees
    localparam int RANDOM_BEATS = 1630;
    localparam int DRAIN_AT     = 800;    // random beat after which the pipe is drained
    localparam int DRAIN_CYCLES = 12;     // six-stage pipe plus margin
    localparam int IDLE_LIMIT   = 1000;   // watchdog: cycles with no beat either way

    typedef struct packed {
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [8:0]  val;
    } t_hsv_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_pixel;

    // expected result plus the pixel it came from, for the mismatch line
    typedef struct packed {
        t_hsv_pixel px;
        t_rgb_pixel rgb;
    } t_rgb_due;

    // directed row: typed = 1 means rgb holds the hand-computed answer
    typedef struct packed {
        t_hsv_pixel px;
        bit         typed;
        t_rgb_pixel rgb;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_hue;
    logic [8:0]  i_saturation;
    logic [8:0]  i_brightness;
    logic        o_strobe;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;

    t_rgb_due rgb_due[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    bit       burst = 1'b0;     // stretch with no start gaps

    hsv_to_rgb_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_strobe     (o_strobe),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Directed table. Typed rows: black, grey, clamp, the six sector corners
    // at full S and V, and hue wrap both ways. The rest go through the model:
    // hue extremes, sector edges, tiny S and V, over-range S and V.
    localparam t_stim_row DIRECTED[24] = '{
        '{'{16'd0,     9'd0,   9'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{'{16'h7FFF,  9'd256, 9'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0  }},
        '{'{16'd0,     9'd0,   9'd256}, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{'{16'd100,   9'd0,   9'd511}, 1'b1, '{8'd255, 8'd255, 8'd255}},
        '{'{16'd0,     9'd256, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{'{16'd960,   9'd256, 9'd256}, 1'b1, '{8'd255, 8'd255, 8'd0  }},
        '{'{16'd1920,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd255, 8'd0  }},
        '{'{16'd2880,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd255, 8'd255}},
        '{'{16'd3840,  9'd256, 9'd256}, 1'b1, '{8'd0,   8'd0,   8'd255}},
        '{'{16'd4800,  9'd256, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd255}},
        '{'{16'd5760,  9'd511, 9'd256}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{'{16'hE980,  9'd256, 9'd511}, 1'b1, '{8'd255, 8'd0,   8'd0  }},
        '{'{16'h8000,  9'd200, 9'd180}, 1'b0, '0},
        '{'{16'h7FFF,  9'd1,   9'd1  }, 1'b0, '0},
        '{'{16'hFFFF,  9'd256, 9'd256}, 1'b0, '0},
        '{'{16'd5759,  9'd128, 9'd256}, 1'b0, '0},
        '{'{16'd959,   9'd511, 9'd511}, 1'b0, '0},
        '{'{16'd961,   9'd3,   9'd255}, 1'b0, '0},
        '{'{16'd3000,  9'd257, 9'd100}, 1'b0, '0},
        '{'{16'hF000,  9'd64,  9'd300}, 1'b0, '0},
        '{'{16'h5555,  9'h1AA, 9'h155}, 1'b0, '0},
        '{'{16'd1,     9'd256, 9'd1  }, 1'b0, '0},
        '{'{16'd4799,  9'd255, 9'd256}, 1'b0, '0},
        '{'{16'hAAAA,  9'h1FF, 9'h1FF}, 1'b0, '0}
    };

    // Bit-exact pixel model. Hue wraps mod 360 degrees, S and V clamp to 1.0,
    // sector fraction is truncated to Q0.16, levels are exact in Q.32 and each
    // channel is floor(level * 255).
    function automatic t_rgb_pixel rgb_of_hsv(t_hsv_pixel px);
        int              hue_w;
        longint unsigned s, v, rem, frac;
        longint unsigned lvl_v, lvl_p, lvl_q, lvl_t;
        longint unsigned lvl_r, lvl_g, lvl_b;
        t_sector         sector;
        t_rgb_pixel      rgb;
        hue_w = int'($signed(px.hue)) % HUE_FULL;
        if (hue_w < 0) begin
            hue_w += HUE_FULL;
        end
        s = (px.sat > Q8_ONE) ? Q8_ONE : px.sat;
        v = (px.val > Q8_ONE) ? Q8_ONE : px.val;
        if (v == 0) begin
            rgb = '0;
        end else if (s == 0) begin
            // grey: V in Q.8 times 255
            rgb.red   = 8'((v * 255) >> 8);
            rgb.green = rgb.red;
            rgb.blue  = rgb.red;
        end else begin
            sector = t_sector'(hue_w / HUE_SECTOR);
            rem    = longint'(hue_w % HUE_SECTOR);
            frac   = (rem << 16) / HUE_SECTOR;
            lvl_v  = v << 24;
            lvl_p  = (v * (Q8_ONE - s)) << 16;
            lvl_q  = v * ((64'd1 << 24) - s * frac);
            lvl_t  = v * ((64'd1 << 24) - s * ((64'd1 << 16) - frac));
            case (sector)
                SEC_RED_YEL: begin lvl_r = lvl_v; lvl_g = lvl_t; lvl_b = lvl_p; end
                SEC_YEL_GRN: begin lvl_r = lvl_q; lvl_g = lvl_v; lvl_b = lvl_p; end
                SEC_GRN_CYN: begin lvl_r = lvl_p; lvl_g = lvl_v; lvl_b = lvl_t; end
                SEC_CYN_BLU: begin lvl_r = lvl_p; lvl_g = lvl_q; lvl_b = lvl_v; end
                SEC_BLU_MAG: begin lvl_r = lvl_t; lvl_g = lvl_p; lvl_b = lvl_v; end
                default:     begin lvl_r = lvl_v; lvl_g = lvl_p; lvl_b = lvl_q; end
            endcase
            rgb.red   = 8'((lvl_r * 255) >> 32);
            rgb.green = 8'((lvl_g * 255) >> 32);
            rgb.blue  = 8'((lvl_b * 255) >> 32);
        end
        return rgb;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // start gap: mostly none, some short, a few long; none during a burst
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (burst || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // Q1.8 level: mostly legal, some corner values, some over-range for clamp
    function automatic logic [8:0] pick_q8();
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            return 9'($urandom_range(0, 256));
        end else if (r < 88) begin
            case ($urandom_range(3))
                0:       return 9'd0;
                1:       return 9'd1;
                2:       return 9'd255;
                default: return 9'd256;
            endcase
        end
        return 9'($urandom_range(257, 511));
    endfunction

    function automatic t_hsv_pixel pick_pixel();
        t_hsv_pixel px;
        int         base;
        if ($urandom_range(99) < 15) begin
            // near a sector edge, shifted by a random number of full turns
            base   = HUE_SECTOR * $urandom_range(0, 5) + $urandom_range(0, 3)
                   + HUE_FULL * $urandom_range(0, 10) - 5 * HUE_FULL;
            px.hue = 16'(base);
        end else begin
            px.hue = 16'($urandom);
        end
        px.sat = pick_q8();
        px.val = pick_q8();
        return px;
    endfunction

    // One pixel beat. start is written once per edge: lowered only when a
    // gap follows, otherwise it stays high across back-to-back beats.
    task automatic send_pixel(t_hsv_pixel px, t_rgb_pixel want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_hue        <= px.hue;
        i_saturation <= px.sat;
        i_brightness <= px.val;
        do @(posedge i_clk); while (busy);
        rgb_due.push_back('{px, want});
    endtask

    // Result checker: o_strobe is sampled as it was during the cycle that
    // this edge ends, so each strobe is seen exactly once.
    always @(posedge i_clk) begin
        t_rgb_due due;
        if (i_rst_n && o_strobe) begin
            if (rgb_due.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0d/%0d with no pixel pending",
                                          o_red, o_green, o_blue));
            end else begin
                due = rgb_due.pop_front();
                if (o_red !== due.rgb.red)
                    report_mismatch($sformatf("hue %h sat %0d val %0d: red %0d, want %0d",
                        due.px.hue, due.px.sat, due.px.val, o_red, due.rgb.red));
                if (o_green !== due.rgb.green)
                    report_mismatch($sformatf("hue %h sat %0d val %0d: green %0d, want %0d",
                        due.px.hue, due.px.sat, due.px.val, o_green, due.rgb.green));
                if (o_blue !== due.rgb.blue)
                    report_mismatch($sformatf("hue %h sat %0d val %0d: blue %0d, want %0d",
                        due.px.hue, due.px.sat, due.px.val, o_blue, due.rgb.blue));
            end
        end
    end

    // Watchdog: any beat in or out clears the count.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_hsv_pixel px;
        start        <= 1'b0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        i_rst_n      <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[k]) begin
            send_pixel(DIRECTED[k].px,
                       DIRECTED[k].typed ? DIRECTED[k].rgb : rgb_of_hsv(DIRECTED[k].px));
        end

        // random run; bursts with no gaps come and go every 150 beats
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 150 == 0) begin
                burst = ($urandom_range(2) == 0);
            end
            px = pick_pixel();
            send_pixel(px, rgb_of_hsv(px));
            if (n == DRAIN_AT) begin
                // hold off until the pipe is empty, then resume
                start <= 1'b0;
                while (rgb_due.size() != 0) @(posedge i_clk);
            end
        end
        start <= 1'b0;

        while (rgb_due.size() != 0) @(posedge i_clk);
        // catch any stray strobe behind the last result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
